>>> hdl/script_token_scanner_top_assert.svh
// assertion macros for the token scanner
`ifndef SCRIPT_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_TOP_ASSERT_SVH
`ifndef SYNTH
`define TSS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TSS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TSS_ASSERT(lbl, cond, msg)
`define TSS_ASSERT_IMPL(lbl, ante, cons, msg)
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// types, token kinds, scan modes and keyword table of the token scanner
// ----------------------------------------------------------------------------
package tss_pkg;

	typedef logic [5:0] kind_t;

	localparam kind_t K_NUMBER  = 6'd0;
	localparam kind_t K_STRING  = 6'd1;
	localparam kind_t K_IDENT   = 6'd2;
	localparam kind_t K_KW_BASE = 6'd3;
	localparam kind_t K_PLUS    = 6'd12;
	localparam kind_t K_MINUS   = 6'd13;
	localparam kind_t K_STAR    = 6'd14;
	localparam kind_t K_SLASH   = 6'd15;
	localparam kind_t K_PERCENT = 6'd16;
	localparam kind_t K_EQ      = 6'd17;
	localparam kind_t K_NE      = 6'd18;
	localparam kind_t K_LT      = 6'd19;
	localparam kind_t K_GT      = 6'd20;
	localparam kind_t K_LE      = 6'd21;
	localparam kind_t K_GE      = 6'd22;
	localparam kind_t K_AND     = 6'd23;
	localparam kind_t K_OR      = 6'd24;
	localparam kind_t K_NOT     = 6'd25;
	localparam kind_t K_ASSIGN  = 6'd26;
	localparam kind_t K_LPAREN  = 6'd27;
	localparam kind_t K_RPAREN  = 6'd28;
	localparam kind_t K_LBRACE  = 6'd29;
	localparam kind_t K_RBRACE  = 6'd30;
	localparam kind_t K_SEMI    = 6'd31;
	localparam kind_t K_COMMA   = 6'd32;
	localparam kind_t K_EOF     = 6'd33;
	localparam kind_t K_ERROR   = 6'd34;

	localparam logic [1:0] E_NONE  = 2'd0;
	localparam logic [1:0] E_CHAR  = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;

	localparam int HOLD_DEPTH = 6;
	localparam int MAX_RESULTS = 8;
	localparam int NUM_KW = 9;

	typedef enum logic [9:0] {
		M_IDLE     = 10'b00_0000_0001,
		M_SLASH    = 10'b00_0000_0010,
		M_COMMENT  = 10'b00_0000_0100,
		M_NUMBER   = 10'b00_0000_1000,
		M_NUMDOT   = 10'b00_0001_0000,
		M_FRACTION = 10'b00_0010_0000,
		M_STRING   = 10'b00_0100_0000,
		M_STRESC   = 10'b00_1000_0000,
		M_IDENT    = 10'b01_0000_0000,
		M_OP2      = 10'b10_0000_0000
	} mode_t;

	typedef struct packed {
		kind_t      kind;
		logic       is_text;
		logic [7:0] text_byte;
		logic [1:0] err;
	} rec_t;

	typedef struct packed {
		logic       free;
		logic [3:0] count;
		logic [2:0] rd_ptr;
	} buf_status_t;

	localparam logic [7:0] KW_TEXT [NUM_KW][HOLD_DEPTH] = '{
		'{"t", "r", "u", "e", 8'd0, 8'd0},
		'{"f", "a", "l", "s", "e", 8'd0},
		'{"l", "e", "t", 8'd0, 8'd0, 8'd0},
		'{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0},
		'{"e", "l", "s", "e", 8'd0, 8'd0},
		'{"w", "h", "i", "l", "e", 8'd0},
		'{"f", "n", 8'd0, 8'd0, 8'd0, 8'd0},
		'{"r", "e", "t", "u", "r", "n"},
		'{"p", "r", "i", "n", "t", 8'd0}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd5, 3'd2,
		3'd6, 3'd5};

	function automatic rec_t mk_rec(kind_t k, logic t, logic [7:0] b, logic [1:0] e);
		rec_t r;
		r.kind = k;
		r.is_text = t;
		r.text_byte = b;
		r.err = e;
		return r;
	endfunction

	// single-character operator kind, K_NUMBER when none
	function automatic kind_t single_op(logic [7:0] b);
		kind_t k;
		case (b)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"%": k = K_PERCENT;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			";": k = K_SEMI;
			",": k = K_COMMA;
			default: k = K_NUMBER;
		endcase
		return k;
	endfunction

	// pending operator with no second character, K_ERROR for lone and/bar
	function automatic kind_t lone_op(logic [7:0] p);
		kind_t k;
		case (p)
			"=": k = K_ASSIGN;
			"!": k = K_NOT;
			"<": k = K_LT;
			">": k = K_GT;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

endpackage

>>> hdl/script_token_scanner_top.sv
// ----------------------------------------------------------------------------
// script_token_scanner_top
// byte-at-a-time token scanner for a small scripting language
// ----------------------------------------------------------------------------
// path: a byte is staged in the input register, and its results are registered in the result buffer
// throughput: one byte per cycle while each byte gives at most one result and out_stall is low;
// a byte that gives several results holds the result buffer until its last result is transferred
// reset: arst_n clears mode, length, pending operator; lines restart at one
// keyword hold bytes are not reset and are only read after being written
module script_token_scanner_top #(
	parameter int LINE_BITS = 20,
	parameter int MAX_NUMBER_TEXT = 63,
	parameter int MAX_IDENT_TEXT = 127
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           source_byte,
	input  logic                 end_of_source,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [5:0]           token_kind,
	output logic                 is_text,
	output logic [7:0]           text_byte,
	output logic [LINE_BITS-1:0] token_line,
	output logic [1:0]           error_code,
	output logic                 last_of_run
);

	`include "script_token_scanner_top_assert.svh"

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       take;

	// batch from the scan step
	logic [3:0]           res_count;
	tss_pkg::rec_t        res_rec [tss_pkg::MAX_RESULTS];
	logic [LINE_BITS-1:0] res_line [tss_pkg::MAX_RESULTS];

	tss_pkg::buf_status_t st;
	tss_pkg::rec_t        out_rec;

	// the staged byte steps the scanner once the result buffer can take its batch
	assign take = valid_s1 && st.free;
	assign in_stall = valid_s1 && !st.free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload only moves on an input transfer
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= source_byte;
			end_s1 <= end_of_source;
		end
	end

	tss_scan_core #(
		.LINE_BITS(LINE_BITS),
		.MAX_NUMBER_TEXT(MAX_NUMBER_TEXT),
		.MAX_IDENT_TEXT(MAX_IDENT_TEXT)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(take),
		.byte_s1(byte_s1),
		.end_s1(end_s1),
		.res_count(res_count),
		.res_rec(res_rec),
		.res_line(res_line)
	);

	// bytes that give no result (whitespace, comment body) skip the buffer
	tss_result_buffer #(
		.LINE_BITS(LINE_BITS)
	) u_buf (
		.clk(clk),
		.arst_n(arst_n),
		.load(take && (res_count != 4'd0)),
		.load_count(res_count),
		.load_rec(res_rec),
		.load_line(res_line),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_rec(out_rec),
		.out_line(token_line),
		.out_last(last_of_run),
		.status(st)
	);

	assign token_kind = out_rec.kind;
	assign is_text = out_rec.is_text;
	assign text_byte = out_rec.text_byte;
	assign error_code = out_rec.err;

	`TSS_ASSERT(a_count_max, st.count <= 4'd8, "result batch over eight")
	`TSS_ASSERT_IMPL(a_rd_range, st.count != 4'd0, ({1'b0, st.rd_ptr} < st.count), "read pointer past batch")
	`TSS_ASSERT_NEXT(a_drain_empty, out_valid && !out_stall && last_of_run && !take, !out_valid, "buffer not empty after last transfer")

endmodule

>>> hdl/tss_scan_core.sv
// ----------------------------------------------------------------------------
// tss_scan_core
// scanner state and the per-byte step logic that builds one result batch
// ----------------------------------------------------------------------------
module tss_scan_core #(
	parameter int LINE_BITS = 20,
	parameter int MAX_NUMBER_TEXT = 63,
	parameter int MAX_IDENT_TEXT = 127
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           byte_s1,
	input  logic                 end_s1,
	output logic [3:0]           res_count,
	output tss_pkg::rec_t        res_rec [tss_pkg::MAX_RESULTS],
	output logic [LINE_BITS-1:0] res_line [tss_pkg::MAX_RESULTS]
);

	localparam int MAX_TEXT = (MAX_NUMBER_TEXT > MAX_IDENT_TEXT) ? MAX_NUMBER_TEXT
		: MAX_IDENT_TEXT;
	localparam int LEN_W = $clog2(MAX_TEXT + 1);
	localparam logic [LEN_W-1:0] NUM_CAP = LEN_W'(MAX_NUMBER_TEXT);
	localparam logic [LEN_W-1:0] ID_CAP = LEN_W'(MAX_IDENT_TEXT);
	localparam logic [LEN_W-1:0] HOLD_LEN = LEN_W'(tss_pkg::HOLD_DEPTH);

	tss_pkg::mode_t       mode_q, m;
	logic [7:0]           pend_q, pend;
	logic [7:0]           hold_q [tss_pkg::HOLD_DEPTH];
	logic [7:0]           hold [tss_pkg::HOLD_DEPTH];
	logic [LEN_W-1:0]     tl_q, tl;
	logic [LINE_BITS-1:0] lc_q, lc, sl_q, sl;

	logic          kw_hit;
	tss_pkg::kind_t kw_kind;

	// keyword match on the held bytes
	always_comb begin
		logic ok;
		kw_hit = 1'b0;
		kw_kind = tss_pkg::K_IDENT;
		for (int i = 0; i < tss_pkg::NUM_KW; i++) begin
			ok = (LEN_W'(tss_pkg::KW_LEN[i]) == tl_q);
			for (int j = 0; j < tss_pkg::HOLD_DEPTH; j++) begin
				if ((j < int'(tss_pkg::KW_LEN[i])) && (hold_q[j] != tss_pkg::KW_TEXT[i][j]))
					ok = 1'b0;
			end
			if (ok) begin
				kw_hit = 1'b1;
				kw_kind = tss_pkg::K_KW_BASE + 6'(i);
			end
		end
	end

	always_comb begin
		logic [3:0]     n;
		logic           fin, do_begin, do_flush, do_close, id_emit;
		tss_pkg::kind_t close_kind, k;
		logic [7:0]     b, eb;
		m = mode_q;
		pend = pend_q;
		hold = hold_q;
		tl = tl_q;
		lc = lc_q;
		sl = sl_q;
		n = 4'd0;
		b = byte_s1;
		fin = end_s1 || (b == 8'd0);
		do_begin = 1'b0;
		do_flush = 1'b0;
		do_close = 1'b0;
		id_emit = 1'b0;
		close_kind = tss_pkg::K_IDENT;
		k = tss_pkg::K_NUMBER;
		eb = b;
		for (int i = 0; i < tss_pkg::MAX_RESULTS; i++) begin
			res_rec[i] = '0;
			res_line[i] = '0;
		end

		// mode-specific work ahead of identifier close
		case (mode_q)
			tss_pkg::M_SLASH: begin
				if (!fin && (b == "/")) begin
					m = tss_pkg::M_COMMENT;
				end else begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_SLASH, 1'b0, 8'd0,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					do_begin = !fin;
				end
			end
			tss_pkg::M_COMMENT: begin
				if (!fin && (b == 8'd10)) begin
					if (lc != '1) lc = lc + 1'b1;
					m = tss_pkg::M_IDLE;
				end
			end
			tss_pkg::M_NUMBER, tss_pkg::M_FRACTION: begin
				if (!fin && tss_pkg::is_digit(b)) begin
					if (tl < NUM_CAP) begin
						res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_NUMBER, 1'b1, b,
							tss_pkg::E_NONE);
						res_line[n[2:0]] = sl;
						n = n + 4'd1;
						tl = tl + 1'b1;
					end
				end else if (!fin && (b == ".") && (mode_q == tss_pkg::M_NUMBER)) begin
					m = tss_pkg::M_NUMDOT;
				end else begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_NUMBER, 1'b0, 8'd0,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					do_begin = !fin;
				end
			end
			tss_pkg::M_NUMDOT: begin
				if (!fin && tss_pkg::is_digit(b)) begin
					if (tl < NUM_CAP) begin
						res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_NUMBER, 1'b1, ".",
							tss_pkg::E_NONE);
						res_line[n[2:0]] = sl;
						n = n + 4'd1;
						tl = tl + 1'b1;
					end
					if (tl < NUM_CAP) begin
						res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_NUMBER, 1'b1, b,
							tss_pkg::E_NONE);
						res_line[n[2:0]] = sl;
						n = n + 4'd1;
						tl = tl + 1'b1;
					end
					m = tss_pkg::M_FRACTION;
				end else begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_NUMBER, 1'b0, 8'd0,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					// dangling dot
					sl = lc;
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_ERROR, 1'b0, ".",
						tss_pkg::E_CHAR);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					do_begin = !fin;
				end
			end
			tss_pkg::M_STRING, tss_pkg::M_STRESC: begin
				if (fin) begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_ERROR, 1'b0, 8'd0,
						tss_pkg::E_UNTERM);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
				end else if ((mode_q == tss_pkg::M_STRING) && (b == "\"")) begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_STRING, 1'b0, 8'd0,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					m = tss_pkg::M_IDLE;
				end else if ((mode_q == tss_pkg::M_STRING) && (b == "\\")) begin
					m = tss_pkg::M_STRESC;
				end else begin
					if ((b == 8'd10) && (lc != '1)) lc = lc + 1'b1;
					if (mode_q == tss_pkg::M_STRESC) begin
						if (b == "n") eb = 8'd10;
						else if (b == "t") eb = 8'd9;
					end
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_STRING, 1'b1, eb,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					m = tss_pkg::M_STRING;
				end
			end
			tss_pkg::M_IDENT: begin
				if (!fin && (tss_pkg::is_alpha(b) || tss_pkg::is_digit(b) || (b == "_")))
				begin
					if (tl < HOLD_LEN) begin
						hold[tl[2:0]] = b;
						tl = tl + 1'b1;
					end else begin
						do_flush = (tl == HOLD_LEN);
						id_emit = (tl < ID_CAP);
					end
				end else begin
					do_close = 1'b1;
					do_flush = (tl <= HOLD_LEN) && !kw_hit;
					close_kind = ((tl <= HOLD_LEN) && kw_hit) ? kw_kind : tss_pkg::K_IDENT;
					do_begin = !fin;
				end
			end
			tss_pkg::M_OP2: begin
				m = tss_pkg::M_IDLE;
				if (!fin && (b == "=") && ((pend_q == "=") || (pend_q == "!") ||
					(pend_q == "<") || (pend_q == ">"))) begin
					if (pend_q == "=") k = tss_pkg::K_EQ;
					else if (pend_q == "!") k = tss_pkg::K_NE;
					else if (pend_q == "<") k = tss_pkg::K_LE;
					else k = tss_pkg::K_GE;
					res_rec[n[2:0]] = tss_pkg::mk_rec(k, 1'b0, 8'd0, tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
				end else if (!fin && (pend_q == "&") && (b == "&")) begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_AND, 1'b0, 8'd0,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
				end else if (!fin && (pend_q == "|") && (b == "|")) begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_OR, 1'b0, 8'd0,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
				end else begin
					k = tss_pkg::lone_op(pend_q);
					if (k == tss_pkg::K_ERROR)
						res_rec[n[2:0]] = tss_pkg::mk_rec(k, 1'b0, pend_q, tss_pkg::E_CHAR);
					else
						res_rec[n[2:0]] = tss_pkg::mk_rec(k, 1'b0, 8'd0, tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					do_begin = !fin;
				end
			end
			default: begin
				do_begin = !fin;
			end
		endcase

		// held identifier bytes
		if (do_flush) begin
			for (int i = 0; i < tss_pkg::HOLD_DEPTH; i++) begin
				if (LEN_W'(i) < tl_q) begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_IDENT, 1'b1, hold_q[i],
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
				end
			end
		end
		if (id_emit) begin
			res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_IDENT, 1'b1, b, tss_pkg::E_NONE);
			res_line[n[2:0]] = sl;
			n = n + 4'd1;
			tl = tl + 1'b1;
		end
		if (do_close) begin
			res_rec[n[2:0]] = tss_pkg::mk_rec(close_kind, 1'b0, 8'd0, tss_pkg::E_NONE);
			res_line[n[2:0]] = sl;
			n = n + 4'd1;
		end

		if (fin) begin
			sl = lc;
			res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_EOF, 1'b0, 8'd0, tss_pkg::E_NONE);
			res_line[n[2:0]] = sl;
			n = n + 4'd1;
			m = tss_pkg::M_IDLE;
			tl = '0;
		end else if (do_begin) begin
			m = tss_pkg::M_IDLE;
			if (tss_pkg::is_space(b)) begin
				if ((b == 8'd10) && (lc != '1)) lc = lc + 1'b1;
			end else begin
				sl = lc;
				tl = '0;
				if (b == "/") begin
					m = tss_pkg::M_SLASH;
				end else if (tss_pkg::is_digit(b)) begin
					res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_NUMBER, 1'b1, b,
						tss_pkg::E_NONE);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
					tl = LEN_W'(1);
					m = tss_pkg::M_NUMBER;
				end else if (b == "\"") begin
					m = tss_pkg::M_STRING;
				end else if (tss_pkg::is_alpha(b) || (b == "_")) begin
					hold[0] = b;
					tl = LEN_W'(1);
					m = tss_pkg::M_IDENT;
				end else if ((b == "=") || (b == "!") || (b == "<") || (b == ">") ||
					(b == "&") || (b == "|")) begin
					pend = b;
					m = tss_pkg::M_OP2;
				end else begin
					k = tss_pkg::single_op(b);
					if (k != tss_pkg::K_NUMBER)
						res_rec[n[2:0]] = tss_pkg::mk_rec(k, 1'b0, 8'd0, tss_pkg::E_NONE);
					else
						res_rec[n[2:0]] = tss_pkg::mk_rec(tss_pkg::K_ERROR, 1'b0, b,
							tss_pkg::E_CHAR);
					res_line[n[2:0]] = sl;
					n = n + 4'd1;
				end
			end
		end
		res_count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tss_pkg::M_IDLE;
			pend_q <= '0;
			tl_q <= '0;
			lc_q <= LINE_BITS'(1);
			sl_q <= LINE_BITS'(1);
		end else if (fire) begin
			mode_q <= m;
			pend_q <= pend;
			tl_q <= tl;
			lc_q <= lc;
			sl_q <= sl;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) hold_q <= hold;
	end

endmodule

>>> hdl/tss_result_buffer.sv
// ----------------------------------------------------------------------------
// tss_result_buffer
// holds one batch of results and hands them out one per transfer
// ----------------------------------------------------------------------------
module tss_result_buffer #(
	parameter int LINE_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [3:0]            load_count,
	input  tss_pkg::rec_t         load_rec [tss_pkg::MAX_RESULTS],
	input  logic [LINE_BITS-1:0]  load_line [tss_pkg::MAX_RESULTS],
	input  logic                  out_stall,
	output logic                  out_valid,
	output tss_pkg::rec_t         out_rec,
	output logic [LINE_BITS-1:0]  out_line,
	output logic                  out_last,
	output tss_pkg::buf_status_t  status
);

	logic [3:0]           cnt_q;
	logic [2:0]           rd_q;
	tss_pkg::rec_t        rec_q [tss_pkg::MAX_RESULTS];
	logic [LINE_BITS-1:0] line_q [tss_pkg::MAX_RESULTS];
	logic                 fire;

	assign out_valid = (cnt_q != 4'd0);
	assign out_rec = rec_q[rd_q];
	assign out_line = line_q[rd_q];
	assign out_last = ({1'b0, rd_q} == (cnt_q - 4'd1));
	assign fire = out_valid && !out_stall;

	assign status.free = !out_valid || (fire && out_last);
	assign status.count = cnt_q;
	assign status.rd_ptr = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			cnt_q <= load_count;
			rd_q <= '0;
		end else if (fire) begin
			if (out_last) begin
				cnt_q <= '0;
				rd_q <= '0;
			end else begin
				rd_q <= rd_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= load_rec;
			line_q <= load_line;
		end
	end

endmodule
